// ===== hdl/dpe_pkg.sv =====
// shared constants for the delimited packet echo block
package dpe_pkg;

    localparam int BYTE_W              = 8;
    localparam int CFG_INDEX_W         = 8;
    localparam int PACKET_DEPTH_DEF    = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARKER   = CFG_INDEX_W'(1);

    // marker values after reset
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h40;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h23;

endpackage

// ===== hdl/delimited_packet_echo.sv =====
// delimited packet framer: stores a packet between markers and echoes it
//
//  channel  | dir | signals                          | contents
//  ---------+-----+----------------------------------+---------------------------
//  s        | in  | s_tvalid s_tready s_tdata        | received byte
//  m        | out | m_tvalid m_tready m_tdata m_tlast | echoed byte, last of packet
//  cfg      | in  | cfg_valid cfg_ready cfg_index     | marker register writes
//           |     | cfg_data                          |
//
// received bytes are taken while no sweep runs; an end marker that closes a packet of n bytes
// (n up to PACKET_DEPTH) starts a read sweep of the packet store, one read a cycle
// at full output rate, and the input is held off until the sweep has read the packet.
// store reads are registered; a two-stage output path (read data, output
// register) follows the store, and while m_tready is low the sweep halts once both
// stages hold a byte, which holds the input off for as long as the stall lasts.
// reset clears control state only; the store holds no reset value and is always
// written before it is read.
module delimited_packet_echo #(
    parameter int PACKET_DEPTH = dpe_pkg::PACKET_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dpe_pkg::BYTE_W-1:0]         s_tdata,    // [7:0] rx_byte
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dpe_pkg::BYTE_W-1:0]         m_tdata,    // [7:0] tx_byte
    output logic                               m_tlast,    // last_byte
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dpe_pkg::BYTE_W-1:0]         cfg_data
);
    import dpe_pkg::*;

    localparam int IDX_W  = $clog2(PACKET_DEPTH);
    localparam int FILL_W = $clog2(PACKET_DEPTH + 1);
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(PACKET_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_CAP  = FILL_W'(PACKET_DEPTH - 1);

    // packet store
    logic [BYTE_W-1:0] store_mem [PACKET_DEPTH];
    logic [BYTE_W-1:0] mem_rdata_reg;

    // control state
    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic              in_packet_reg, in_packet_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              emit_reg, emit_next;
    logic [IDX_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]  emit_last_reg, emit_last_next;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic              s_xfer;
    logic              is_start;
    logic              is_end;
    logic [IDX_W-1:0]  slot;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic              rd_move;

    assign cfg_ready = 1'b1;
    assign s_tready  = !emit_reg;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    // classify the incoming byte; start test wins when markers are equal
    assign is_start = (s_tdata == start_marker_reg);
    assign is_end   = !is_start && (s_tdata == end_marker_reg);
    assign slot     = (fill_reg >= FILL_CAP) ? LAST_SLOT : fill_reg[IDX_W-1:0];

    // output path handshakes
    assign rd_move = rd_valid_reg && (!out_valid_reg || m_tready);
    assign rd_en   = emit_reg && (!rd_valid_reg || rd_move);

    // framing and sweep control
    always_comb
    begin
        in_packet_next = in_packet_reg;
        fill_next      = fill_reg;
        emit_next      = emit_reg;
        rd_addr_next   = rd_addr_reg;
        emit_last_next = emit_last_reg;
        wr_en          = 1'b0;
        wr_addr        = slot;
        if (s_xfer)
        begin
            if (is_start)
            begin
                in_packet_next = 1'b1;
                fill_next      = FILL_W'(1);
                wr_en          = 1'b1;
                wr_addr        = '0;
            end
            else if (is_end)
            begin
                if (in_packet_reg)
                begin
                    in_packet_next = 1'b0;
                    fill_next      = FILL_W'(slot) + FILL_W'(1);
                    wr_en          = 1'b1;
                    emit_next      = 1'b1;
                    rd_addr_next   = '0;
                    emit_last_next = slot;
                end
            end
            else if (in_packet_reg)
            begin
                wr_en     = 1'b1;
                fill_next = (slot == LAST_SLOT) ? FILL_CAP : FILL_W'(slot) + FILL_W'(1);
            end
        end
        else if (rd_en)
        begin
            rd_addr_next = rd_addr_reg + IDX_W'(1);
            if (rd_addr_reg == emit_last_reg)
            begin
                emit_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            in_packet_reg    <= 1'b0;
            fill_reg         <= '0;
            emit_reg         <= 1'b0;
            rd_addr_reg      <= '0;
            emit_last_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_MARKER: start_marker_reg <= cfg_data;
                    CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            in_packet_reg <= in_packet_next;
            fill_reg      <= fill_next;
            emit_reg      <= emit_next;
            rd_addr_reg   <= rd_addr_next;
            emit_last_reg <= emit_last_next;
            // read data stage
            if (rd_en)
            begin
                rd_valid_reg <= 1'b1;
                rd_last_reg  <= (rd_addr_reg == emit_last_reg);
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end
            // output register
            if (rd_move)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= rd_last_reg;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= s_tdata;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= store_mem[rd_addr_reg];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            out_data_reg <= mem_rdata_reg;
        end
    end

endmodule
